/* sv/bcpt_pkg.sv */
// bcpt_pkg: shared widths, event codes, controller states and command struct
// for the book cancel pressure tracker; no dependencies
package bcpt_pkg;

   localparam int QTY_W   = 48;   // signed quantity / depth on the input side
   localparam int MAG_W   = 47;   // clamped magnitude
   localparam int ACC_W   = 48;   // pending trade accumulator
   localparam int PX_W    = 14;   // prices, tick size and quotients
   localparam int KIND_W  = 2;
   localparam int SIDE_W  = 2;
   localparam int SIGN_W  = 2;
   localparam int STEP_W  = $clog2(PX_W);

   localparam logic [SIGN_W-1:0] LANE_SIGN_RESET = 2'sd1;
   localparam logic [SIGN_W-1:0] LANE_SIGN_POS   = 2'b01;
   localparam logic [SIGN_W-1:0] LANE_SIGN_NEG   = 2'b11;

   localparam logic [KIND_W-1:0] KIND_BOOK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TRADE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OTHER   = 2'd3;

   localparam logic [SIDE_W-1:0] SIDE_BUY  = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_SELL = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;     // capture the item and seed the dividers
      logic step;     // one quotient bit
      logic commit;   // update tracker state, load the result register
   } ctrl_cmd_type;

endpackage

/* sv/bcpt_div.sv */
// bcpt_div: restoring divider, one quotient bit per step
// depends on bcpt_pkg
module bcpt_div (
   input  logic                      clock,
   input  logic                      load,
   input  logic                      step,
   input  logic [bcpt_pkg::PX_W-1:0] dividend,
   input  logic [bcpt_pkg::PX_W-1:0] divisor,
   output logic [bcpt_pkg::PX_W-1:0] quotient
);
   import bcpt_pkg::*;

   logic [PX_W-1:0] rem_ff, rem_in;
   logic [PX_W-1:0] quo_ff, quo_in;
   logic [PX_W-1:0] dvs_ff, dvs_in;
   logic [PX_W:0]   trial;
   logic [PX_W:0]   diff;
   logic            ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[PX_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      ge     = (trial >= {1'b0, dvs_ff});
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (load) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (step) begin
         rem_in = ge ? diff[PX_W-1:0] : trial[PX_W-1:0];
         quo_in = {quo_ff[PX_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;

endmodule

/* sv/bcpt_ctrl.sv */
// bcpt_ctrl: sequencer for accept, divide, commit and result handoff
// depends on bcpt_pkg
module bcpt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bcpt_pkg::ctrl_cmd_type cmd
);
   import bcpt_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PX_W - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              valid_ff, valid_in;
   logic              slot_free;

   assign slot_free = !valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == LAST_STEP) state_in = ST_DONE;
         ST_DONE: if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      cnt_in     = cnt_ff;
      valid_in   = valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            cnt_in    = '0;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
         end
         ST_DONE: begin
            cmd.commit = slot_free;
            if (slot_free) valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

/* sv/bcpt_dp.sv */
// bcpt_dp: item capture, tracker state, cancel estimate and result register
// depends on bcpt_pkg and bcpt_div
module bcpt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  bcpt_pkg::ctrl_cmd_type        cmd,
   input  logic                          csr_we,
   input  logic signed [bcpt_pkg::SIGN_W-1:0] csr_wdata,
   input  logic [bcpt_pkg::KIND_W-1:0]   req_event_kind,
   input  logic [bcpt_pkg::SIDE_W-1:0]   req_trade_side,
   input  logic signed [bcpt_pkg::QTY_W-1:0] req_trade_quantity,
   input  logic                          req_book_ok,
   input  logic                          req_lineage_ok,
   input  logic [bcpt_pkg::PX_W-1:0]     req_tick_size,
   input  logic [bcpt_pkg::PX_W-1:0]     req_best_bid_price,
   input  logic [bcpt_pkg::PX_W-1:0]     req_best_ask_price,
   input  logic signed [bcpt_pkg::QTY_W-1:0] req_bid_depth_five,
   input  logic signed [bcpt_pkg::QTY_W-1:0] req_ask_depth_five,
   output logic                          rsp_feed_healthy,
   output logic                          rsp_ticks_valid,
   output logic [bcpt_pkg::PX_W-1:0]     rsp_bid_tick,
   output logic [bcpt_pkg::PX_W-1:0]     rsp_ask_tick,
   output logic [bcpt_pkg::MAG_W-1:0]    rsp_bid_depth_out,
   output logic [bcpt_pkg::MAG_W-1:0]    rsp_ask_depth_out,
   output logic [bcpt_pkg::MAG_W-1:0]    rsp_buy_trade_delta,
   output logic [bcpt_pkg::MAG_W-1:0]    rsp_sell_trade_delta,
   output logic [bcpt_pkg::MAG_W-1:0]    rsp_bid_cancel_delta,
   output logic [bcpt_pkg::MAG_W-1:0]    rsp_ask_cancel_delta
);
   import bcpt_pkg::*;

   function automatic logic [MAG_W-1:0] clamp(input logic [QTY_W-1:0] v);
      return v[QTY_W-1] ? '0 : v[MAG_W-1:0];
   endfunction

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [MAG_W-1:0] b);
      logic [ACC_W:0] s;
      s = {1'b0, a} + {2'b00, b};
      return s[ACC_W] ? '1 : s[ACC_W-1:0];
   endfunction

   function automatic logic [MAG_W-1:0] removal(input logic [MAG_W-1:0] prev,
                                                input logic [MAG_W-1:0] cur);
      logic [MAG_W:0] d;
      d = {1'b0, prev} - {1'b0, cur};
      return d[MAG_W] ? '0 : d[MAG_W-1:0];
   endfunction

   function automatic logic [MAG_W-1:0] net(input logic [MAG_W-1:0] rem,
                                            input logic [ACC_W-1:0] pend);
      logic [ACC_W:0] d;
      d = {2'b00, rem} - {1'b0, pend};
      return d[ACC_W] ? '0 : d[MAG_W-1:0];
   endfunction

   // configuration
   logic [SIGN_W-1:0] lane_sign_ff;

   // captured item
   logic [KIND_W-1:0] kind_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [MAG_W-1:0]  qty_ff, bid_d_ff, ask_d_ff;
   logic              book_ok_ff, lineage_ok_ff, tick_nz_ff;

   // tracker state
   logic [MAG_W-1:0]  last_bid_ff, last_bid_in, last_ask_ff, last_ask_in;
   logic [ACC_W-1:0]  pend_bid_ff, pend_bid_in, pend_ask_ff, pend_ask_in;
   logic              seen_ff, seen_in;

   // depth contraction, registered from the last and captured depths, settled before the commit
   logic [MAG_W-1:0]  rem_bid_ff, rem_ask_ff;

   logic [PX_W-1:0]   bid_q, ask_q;
   logic              book_good, invalidated, sign_good;
   logic [MAG_W-1:0]  buy_d, sell_d, bid_c, ask_c;

   bcpt_div u_div_bid (
      .clock    (clock),
      .load     (cmd.load),
      .step     (cmd.step),
      .dividend (req_best_bid_price),
      .divisor  (req_tick_size),
      .quotient (bid_q)
   );

   bcpt_div u_div_ask (
      .clock    (clock),
      .load     (cmd.load),
      .step     (cmd.step),
      .dividend (req_best_ask_price),
      .divisor  (req_tick_size),
      .quotient (ask_q)
   );

   always_ff @(posedge clock) begin
      if (reset) lane_sign_ff <= LANE_SIGN_RESET;
      else if (csr_we) lane_sign_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff       <= req_event_kind;
         side_ff       <= req_trade_side;
         qty_ff        <= clamp(req_trade_quantity);
         book_ok_ff    <= req_book_ok;
         lineage_ok_ff <= req_lineage_ok;
         tick_nz_ff    <= (req_tick_size != '0);
         bid_d_ff      <= clamp(req_bid_depth_five);
         ask_d_ff      <= clamp(req_ask_depth_five);
      end
      rem_bid_ff <= removal(last_bid_ff, bid_d_ff);
      rem_ask_ff <= removal(last_ask_ff, ask_d_ff);
   end

   always_comb begin
      sign_good   = (lane_sign_ff == LANE_SIGN_POS) || (lane_sign_ff == LANE_SIGN_NEG);
      book_good   = book_ok_ff && lineage_ok_ff && tick_nz_ff;
      invalidated = (kind_ff == KIND_INVALID);
      buy_d       = '0;
      sell_d      = '0;
      bid_c       = '0;
      ask_c       = '0;
      last_bid_in = last_bid_ff;
      last_ask_in = last_ask_ff;
      pend_bid_in = pend_bid_ff;
      pend_ask_in = pend_ask_ff;
      seen_in     = seen_ff;
      if (kind_ff == KIND_TRADE) begin
         if (side_ff == SIDE_BUY) begin
            buy_d       = qty_ff;
            pend_ask_in = sat_add(pend_ask_ff, qty_ff);
         end else if (side_ff == SIDE_SELL) begin
            sell_d      = qty_ff;
            pend_bid_in = sat_add(pend_bid_ff, qty_ff);
         end
      end
      if (!book_good || invalidated) begin
         last_bid_in = '0;
         last_ask_in = '0;
         pend_bid_in = '0;
         pend_ask_in = '0;
         seen_in     = 1'b0;
      end else if (kind_ff == KIND_BOOK) begin
         if (seen_ff) begin
            bid_c = net(rem_bid_ff, pend_bid_ff);
            ask_c = net(rem_ask_ff, pend_ask_ff);
         end
         last_bid_in = bid_d_ff;
         last_ask_in = ask_d_ff;
         pend_bid_in = '0;
         pend_ask_in = '0;
         seen_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_bid_ff <= '0;
         last_ask_ff <= '0;
         pend_bid_ff <= '0;
         pend_ask_ff <= '0;
         seen_ff     <= 1'b0;
      end else if (cmd.commit) begin
         last_bid_ff <= last_bid_in;
         last_ask_ff <= last_ask_in;
         pend_bid_ff <= pend_bid_in;
         pend_ask_ff <= pend_ask_in;
         seen_ff     <= seen_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_feed_healthy     <= sign_good && book_good && !invalidated;
         rsp_ticks_valid      <= tick_nz_ff;
         rsp_bid_tick         <= tick_nz_ff ? bid_q : '0;
         rsp_ask_tick         <= tick_nz_ff ? ask_q : '0;
         rsp_bid_depth_out    <= bid_d_ff;
         rsp_ask_depth_out    <= ask_d_ff;
         rsp_buy_trade_delta  <= buy_d;
         rsp_sell_trade_delta <= sell_d;
         rsp_bid_cancel_delta <= bid_c;
         rsp_ask_cancel_delta <= ask_c;
      end
   end

endmodule

/* sv/book_cancel_pressure_tracker.sv */
// book_cancel_pressure_tracker: top level, controller plus datapath
// depends on bcpt_pkg, bcpt_ctrl, bcpt_dp (which holds two bcpt_div)
// after accept: 14 divide steps, then commit loads the result register and raises rsp_valid
// one item at a time: a new item is accepted only after the last one commits, paced by the bit-serial tick dividers
// the result register frees the output side; a held result stalls only commit
// reset (synchronous, active high) clears tracker state and sets lane sign to +1
module book_cancel_pressure_tracker (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_we,
   input  logic signed [bcpt_pkg::SIGN_W-1:0]  csr_wdata,
   // input item channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bcpt_pkg::KIND_W-1:0]         req_event_kind,
   input  logic [bcpt_pkg::SIDE_W-1:0]         req_trade_side,
   input  logic signed [bcpt_pkg::QTY_W-1:0]   req_trade_quantity,
   input  logic                                req_book_ok,
   input  logic                                req_lineage_ok,
   input  logic [bcpt_pkg::PX_W-1:0]           req_tick_size,
   input  logic [bcpt_pkg::PX_W-1:0]           req_best_bid_price,
   input  logic [bcpt_pkg::PX_W-1:0]           req_best_ask_price,
   input  logic signed [bcpt_pkg::QTY_W-1:0]   req_bid_depth_five,
   input  logic signed [bcpt_pkg::QTY_W-1:0]   req_ask_depth_five,
   // result item channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_feed_healthy,
   output logic                                rsp_ticks_valid,
   output logic [bcpt_pkg::PX_W-1:0]           rsp_bid_tick,
   output logic [bcpt_pkg::PX_W-1:0]           rsp_ask_tick,
   output logic [bcpt_pkg::MAG_W-1:0]          rsp_bid_depth_out,
   output logic [bcpt_pkg::MAG_W-1:0]          rsp_ask_depth_out,
   output logic [bcpt_pkg::MAG_W-1:0]          rsp_buy_trade_delta,
   output logic [bcpt_pkg::MAG_W-1:0]          rsp_sell_trade_delta,
   output logic [bcpt_pkg::MAG_W-1:0]          rsp_bid_cancel_delta,
   output logic [bcpt_pkg::MAG_W-1:0]          rsp_ask_cancel_delta
);
   import bcpt_pkg::*;

   // load / step / commit strobes from the sequencer
   ctrl_cmd_type cmd;

   // sequencer: idle until an item arrives, then 14 divide steps, then commit
   // once the result register is empty or being drained
   bcpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath: item capture with clamping, two tick dividers, cancel estimate,
   // saturating trade accumulators and the result register
   bcpt_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .req_event_kind       (req_event_kind),
      .req_trade_side       (req_trade_side),
      .req_trade_quantity   (req_trade_quantity),
      .req_book_ok          (req_book_ok),
      .req_lineage_ok       (req_lineage_ok),
      .req_tick_size        (req_tick_size),
      .req_best_bid_price   (req_best_bid_price),
      .req_best_ask_price   (req_best_ask_price),
      .req_bid_depth_five   (req_bid_depth_five),
      .req_ask_depth_five   (req_ask_depth_five),
      .rsp_feed_healthy     (rsp_feed_healthy),
      .rsp_ticks_valid      (rsp_ticks_valid),
      .rsp_bid_tick         (rsp_bid_tick),
      .rsp_ask_tick         (rsp_ask_tick),
      .rsp_bid_depth_out    (rsp_bid_depth_out),
      .rsp_ask_depth_out    (rsp_ask_depth_out),
      .rsp_buy_trade_delta  (rsp_buy_trade_delta),
      .rsp_sell_trade_delta (rsp_sell_trade_delta),
      .rsp_bid_cancel_delta (rsp_bid_cancel_delta),
      .rsp_ask_cancel_delta (rsp_ask_cancel_delta)
   );

endmodule
